// ===== rtl/ufrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufrc_pkg
// shared constants, codes and the token type passed from the front end
// through the queue to the back end of the reassembly checker
// ----------------------------------------------------------------------------
package ufrc_pkg;

   localparam int POS_W     = 11;
   localparam int OFF_W     = 22;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

   localparam logic [OFF_W-1:0] MAX_BLOB_BYTES     = 22'd3072000;
   localparam logic [POS_W-1:0] MAX_DATAGRAM_BYTES = 11'd1472;
   localparam logic [POS_W-1:0] HDR_BYTES          = 11'd26;
   localparam logic [POS_W-1:0] HDR_TRAILER_BYTES  = 11'd30;

   localparam logic [15:0] VERSION_OK = 16'h0001;
   localparam logic [7:0]  TYPE_DATA  = 8'h62;
   localparam int          LAST_BIT   = 7;

   // header byte positions
   localparam logic [POS_W-1:0] HB_BLOB_HI = 11'd0;
   localparam logic [POS_W-1:0] HB_BLOB_LO = 11'd1;
   localparam logic [POS_W-1:0] HB_FRAG_HI = 11'd2;
   localparam logic [POS_W-1:0] HB_FRAG_LO = 11'd3;
   localparam logic [POS_W-1:0] HB_VER_HI  = 11'd20;
   localparam logic [POS_W-1:0] HB_VER_LO  = 11'd21;
   localparam logic [POS_W-1:0] HB_LEN_HI  = 11'd22;
   localparam logic [POS_W-1:0] HB_LEN_LO  = 11'd23;
   localparam logic [POS_W-1:0] HB_FLAGS   = 11'd24;
   localparam logic [POS_W-1:0] HB_TYPE    = 11'd25;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // fragment status codes
   localparam logic [3:0] ST_MORE     = 4'd0;
   localparam logic [3:0] ST_COMPLETE = 4'd1;
   localparam logic [3:0] ST_SKIPPED  = 4'd2;
   localparam logic [3:0] ST_VERSION  = 4'd3;
   localparam logic [3:0] ST_TYPE     = 4'd4;
   localparam logic [3:0] ST_LENGTH   = 4'd5;
   localparam logic [3:0] ST_BLOB     = 4'd6;
   localparam logic [3:0] ST_FRAGMENT = 4'd7;
   localparam logic [3:0] ST_OVERFLOW = 4'd8;

   typedef struct packed {
      logic             is_eod;
      logic [7:0]       data_byte;
      logic [POS_W-1:0] pay_index;
      logic             pay_ok;
      logic             ver_ok;
      logic             type_ok;
      logic             len_ok;
      logic             last_flag;
      logic [15:0]      blob_number;
      logic [15:0]      fragment_number;
      logic [15:0]      data_length;
   } token_type;

endpackage

// ===== rtl/ufrc_req_if.sv =====
// ----------------------------------------------------------------------------
// ufrc_req_if
// input byte channel: one datagram byte per beat with end mark
// ----------------------------------------------------------------------------
interface ufrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_datagram;

   modport source (output valid, output data_byte, output end_of_datagram, input ready);
   modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

// ===== rtl/ufrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ufrc_rsp_if
// result channel: provisional payload bytes and per-datagram status
// ----------------------------------------------------------------------------
interface ufrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [21:0] byte_offset;
   logic [3:0]  fragment_status;
   logic [15:0] blob_id_seen;
   logic [15:0] fragment_index;
   logic [21:0] blob_total_bytes;

   modport source (output valid, output result_kind, output payload_byte,
                   output byte_offset, output fragment_status, output blob_id_seen,
                   output fragment_index, output blob_total_bytes, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input byte_offset, input fragment_status, input blob_id_seen,
                   input fragment_index, input blob_total_bytes, output ready);
endinterface

// ===== rtl/ufrc_front.sv =====
// ----------------------------------------------------------------------------
// ufrc_front
// header parser: tracks byte position, captures header fields and turns
// payload candidates and datagram ends into tokens for the queue
// ----------------------------------------------------------------------------
module ufrc_front (
   input  logic                clock,
   input  logic                reset,
   ufrc_req_if.sink            req_chan,
   input  logic                full,
   output logic                push,
   output ufrc_pkg::token_type push_token
);

   logic [ufrc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0] blob_ff, blob_in;
   logic [15:0] frag_ff, frag_in;
   logic [15:0] ver_ff, ver_in;
   logic [15:0] len_ff, len_in;
   logic        last_ff, last_in;
   logic [7:0]  ptype_ff, ptype_in;

   logic                       accept;
   logic                       keep;
   logic                       candidate;
   logic [ufrc_pkg::POS_W-1:0] size;
   logic [ufrc_pkg::POS_W-1:0] pay_index;
   logic [ufrc_pkg::POS_W-1:0] size_less;

   assign req_chan.ready = !full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      keep      = pos_ff < ufrc_pkg::MAX_DATAGRAM_BYTES;
      size      = keep ? pos_ff + 1'b1 : ufrc_pkg::MAX_DATAGRAM_BYTES;
      pos_in    = pos_ff;
      blob_in   = blob_ff;
      frag_in   = frag_ff;
      ver_in    = ver_ff;
      len_in    = len_ff;
      last_in   = last_ff;
      ptype_in  = ptype_ff;
      if (keep) begin
         pos_in = pos_ff + 1'b1;
         case (pos_ff)
            ufrc_pkg::HB_BLOB_HI: begin
               blob_in  = {req_chan.data_byte, 8'h00};
               frag_in  = '0;
               ver_in   = '0;
               len_in   = '0;
               last_in  = 1'b0;
               ptype_in = '0;
            end
            ufrc_pkg::HB_BLOB_LO: blob_in = {blob_ff[15:8], req_chan.data_byte};
            ufrc_pkg::HB_FRAG_HI: frag_in = {req_chan.data_byte, 8'h00};
            ufrc_pkg::HB_FRAG_LO: frag_in = {frag_ff[15:8], req_chan.data_byte};
            ufrc_pkg::HB_VER_HI:  ver_in  = {req_chan.data_byte, 8'h00};
            ufrc_pkg::HB_VER_LO:  ver_in  = {ver_ff[15:8], req_chan.data_byte};
            ufrc_pkg::HB_LEN_HI:  len_in  = {req_chan.data_byte, 8'h00};
            ufrc_pkg::HB_LEN_LO:  len_in  = {len_ff[15:8], req_chan.data_byte};
            ufrc_pkg::HB_FLAGS:   last_in = req_chan.data_byte[ufrc_pkg::LAST_BIT];
            ufrc_pkg::HB_TYPE:    ptype_in = req_chan.data_byte;
            default: ;
         endcase
      end
      if (req_chan.end_of_datagram) begin
         pos_in = '0;
      end

      pay_index = pos_ff - ufrc_pkg::HDR_BYTES;
      size_less = size - ufrc_pkg::HDR_TRAILER_BYTES;
      candidate = !req_chan.end_of_datagram && keep && (pos_ff >= ufrc_pkg::HDR_BYTES);

      push_token.is_eod          = req_chan.end_of_datagram;
      push_token.data_byte       = req_chan.data_byte;
      push_token.pay_index       = pay_index;
      push_token.ver_ok          = ver_in == ufrc_pkg::VERSION_OK;
      push_token.type_ok         = ptype_in == ufrc_pkg::TYPE_DATA;
      push_token.pay_ok          = push_token.ver_ok && push_token.type_ok &&
                                   ({5'b0, pay_index} < len_in);
      push_token.len_ok          = (size >= ufrc_pkg::HDR_TRAILER_BYTES) &&
                                   (len_in == {5'b0, size_less});
      push_token.last_flag       = last_in;
      push_token.blob_number     = blob_in;
      push_token.fragment_number = frag_in;
      push_token.data_length     = len_in;
   end

   assign push = accept && (req_chan.end_of_datagram || candidate);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         blob_ff  <= '0;
         frag_ff  <= '0;
         ver_ff   <= '0;
         len_ff   <= '0;
         last_ff  <= 1'b0;
         ptype_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         blob_ff  <= blob_in;
         frag_ff  <= frag_in;
         ver_ff   <= ver_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
         ptype_ff <= ptype_in;
      end
   end

endmodule

// ===== rtl/ufrc_queue.sv =====
// ----------------------------------------------------------------------------
// ufrc_queue
// short token queue between the parser and the checker
// ----------------------------------------------------------------------------
module ufrc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ufrc_pkg::token_type push_token,
   output logic                full,
   input  logic                pop,
   output ufrc_pkg::token_type head_token,
   output logic                empty
);

   ufrc_pkg::token_type entry_ff [ufrc_pkg::QUEUE_DEPTH];

   logic [ufrc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ufrc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ufrc_pkg::QPTR_W:0]   count_ff, count_in;

   assign full       = count_ff == (ufrc_pkg::QPTR_W+1)'(ufrc_pkg::QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ufrc_back.sv =====
// ----------------------------------------------------------------------------
// ufrc_back
// blob checker: holds blob state, decides payload emission and datagram
// status, and drives the registered result channel
// ----------------------------------------------------------------------------
module ufrc_back (
   input  logic                clock,
   input  logic                reset,
   input  ufrc_pkg::token_type head_token,
   input  logic                empty,
   output logic                pop,
   ufrc_rsp_if.source          rsp_chan
);

   logic                       in_blob_ff, in_blob_in;
   logic [15:0]                cur_blob_ff, cur_blob_in;
   logic [15:0]                exp_frag_ff, exp_frag_in;
   logic [ufrc_pkg::OFF_W-1:0] committed_ff, committed_in;

   logic                       valid_ff, valid_in;
   logic                       kind_ff, kind_in;
   logic [7:0]                 pbyte_ff, pbyte_in;
   logic [ufrc_pkg::OFF_W-1:0] offset_ff, offset_in;
   logic [3:0]                 status_ff, status_in;
   logic [15:0]                bid_ff, bid_in;
   logic [15:0]                fidx_ff, fidx_in;
   logic [ufrc_pkg::OFF_W-1:0] total_ff, total_in;

   logic [ufrc_pkg::OFF_W-1:0] base;
   logic [ufrc_pkg::OFF_W-1:0] offset;
   logic [ufrc_pkg::OFF_W-1:0] sum;
   logic                       blob_match;
   logic                       frag_match;
   logic                       pay_emit;
   logic [3:0]                 status;

   assign pop = !empty && (!valid_ff || rsp_chan.ready);

   always_comb begin
      base       = in_blob_ff ? committed_ff : '0;
      offset     = base + {11'b0, head_token.pay_index};
      sum        = base + {6'b0, head_token.data_length};
      blob_match = head_token.blob_number == cur_blob_ff;
      frag_match = in_blob_ff ? (head_token.fragment_number == exp_frag_ff)
                              : (head_token.fragment_number == '0);
      pay_emit   = head_token.pay_ok && frag_match && (!in_blob_ff || blob_match) &&
                   (offset < ufrc_pkg::MAX_BLOB_BYTES);

      if (!head_token.ver_ok) begin
         status = ufrc_pkg::ST_VERSION;
      end else if (!head_token.type_ok) begin
         status = ufrc_pkg::ST_TYPE;
      end else if (!head_token.len_ok) begin
         status = ufrc_pkg::ST_LENGTH;
      end else if (!in_blob_ff && !frag_match) begin
         status = ufrc_pkg::ST_SKIPPED;
      end else if (in_blob_ff && !blob_match) begin
         status = ufrc_pkg::ST_BLOB;
      end else if (in_blob_ff && !frag_match) begin
         status = ufrc_pkg::ST_FRAGMENT;
      end else if (sum > ufrc_pkg::MAX_BLOB_BYTES) begin
         status = ufrc_pkg::ST_OVERFLOW;
      end else if (head_token.last_flag) begin
         status = ufrc_pkg::ST_COMPLETE;
      end else begin
         status = ufrc_pkg::ST_MORE;
      end

      in_blob_in   = in_blob_ff;
      cur_blob_in  = cur_blob_ff;
      exp_frag_in  = exp_frag_ff;
      committed_in = committed_ff;

      valid_in  = valid_ff && !rsp_chan.ready;
      kind_in   = kind_ff;
      pbyte_in  = pbyte_ff;
      offset_in = offset_ff;
      status_in = status_ff;
      bid_in    = bid_ff;
      fidx_in   = fidx_ff;
      total_in  = total_ff;

      if (pop) begin
         if (head_token.is_eod) begin
            valid_in  = 1'b1;
            kind_in   = ufrc_pkg::KIND_STATUS;
            pbyte_in  = '0;
            offset_in = '0;
            status_in = status;
            bid_in    = head_token.blob_number;
            fidx_in   = head_token.fragment_number;
            if (status == ufrc_pkg::ST_MORE || status == ufrc_pkg::ST_COMPLETE) begin
               total_in = sum;
            end else begin
               total_in = base;
            end
            if (status == ufrc_pkg::ST_MORE) begin
               in_blob_in   = 1'b1;
               cur_blob_in  = in_blob_ff ? cur_blob_ff : head_token.blob_number;
               exp_frag_in  = (in_blob_ff ? exp_frag_ff : 16'h0000) + 16'h0001;
               committed_in = sum;
            end else begin
               in_blob_in   = 1'b0;
               exp_frag_in  = '0;
               committed_in = '0;
            end
         end else begin
            valid_in  = pay_emit;
            kind_in   = ufrc_pkg::KIND_PAYLOAD;
            pbyte_in  = head_token.data_byte;
            offset_in = offset;
            status_in = '0;
            bid_in    = '0;
            fidx_in   = '0;
            total_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_blob_ff   <= 1'b0;
         cur_blob_ff  <= '0;
         exp_frag_ff  <= '0;
         committed_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         in_blob_ff   <= in_blob_in;
         cur_blob_ff  <= cur_blob_in;
         exp_frag_ff  <= exp_frag_in;
         committed_ff <= committed_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pbyte_ff  <= pbyte_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
      bid_ff    <= bid_in;
      fidx_ff   <= fidx_in;
      total_ff  <= total_in;
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.result_kind      = kind_ff;
   assign rsp_chan.payload_byte     = pbyte_ff;
   assign rsp_chan.byte_offset      = offset_ff;
   assign rsp_chan.fragment_status  = status_ff;
   assign rsp_chan.blob_id_seen     = bid_ff;
   assign rsp_chan.fragment_index   = fidx_ff;
   assign rsp_chan.blob_total_bytes = total_ff;

`ifndef SYNTH
   a_payload_in_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == ufrc_pkg::KIND_PAYLOAD) |-> offset_ff < ufrc_pkg::MAX_BLOB_BYTES)
      else $error("payload beat offset beyond blob bound");

   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      !in_blob_ff |-> (committed_ff == '0) && (exp_frag_ff == '0))
      else $error("blob state not cleared while hunting");

   a_more_keeps_blob: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == ufrc_pkg::KIND_STATUS) && (status_ff == ufrc_pkg::ST_MORE)
      |-> in_blob_ff && (committed_ff == total_ff))
      else $error("accepted fragment did not commit blob length");

   a_reject_hunts: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (kind_ff == ufrc_pkg::KIND_STATUS) && (status_ff != ufrc_pkg::ST_MORE)
      |-> !in_blob_ff)
      else $error("blob still open after rejection or completion");
`endif

endmodule

// ===== rtl/udp_fragment_reassembly_checker_unit.sv =====
// ----------------------------------------------------------------------------
// udp_fragment_reassembly_checker_unit
// checks fragmented datagrams byte by byte and reports payload and status
// ----------------------------------------------------------------------------
// req_chan takes one datagram byte per beat, end_of_datagram on the last
// byte. rsp_chan gives a provisional payload beat (result_kind 0) with its
// blob offset for each payload byte that passes the checks seen so far, and
// one status beat (result_kind 1) on every datagram end that commits or
// rejects the bytes already sent. header bytes, the check value and dropped
// bytes give no beat.
// throughput is one byte per cycle while the queue is not full. the parser
// writes each token into a four-entry queue and the checker pops it into
// the output register once that register is free, so a result reaches
// rsp_chan through the queue and then the output register.
// reset clears byte position, header fields and blob state; the block starts
// hunting for fragment 0 and the queue and output register are empty.
// when rsp_chan stalls the output register holds its beat, the queue fills,
// and req_chan.ready drops once four tokens are waiting.
// ----------------------------------------------------------------------------
module udp_fragment_reassembly_checker_unit (
   input  logic        clock,
   input  logic        reset,
   ufrc_req_if.sink    req_chan,
   ufrc_rsp_if.source  rsp_chan
);

   ufrc_pkg::token_type push_token;
   ufrc_pkg::token_type head_token;
   logic                push;
   logic                pop;
   logic                full;
   logic                empty;

   ufrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .full       (full),
      .push       (push),
      .push_token (push_token)
   );

   ufrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .full       (full),
      .pop        (pop),
      .head_token (head_token),
      .empty      (empty)
   );

   ufrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_token (head_token),
      .empty      (empty),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
